### sv/kce_pkg.sv
// shared constants, types and codes of the k-means clustering engine
`default_nettype none
package kce_pkg;
  localparam int MAX_POINTS   = 1024;
  localparam int MAX_CLUSTERS = 16;
  localparam int MAX_FEATURES = 8;
  localparam int SAMPLE_WIDTH = 16;

  localparam int PT_AW   = $clog2(MAX_POINTS);
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int CL_W    = $clog2(MAX_CLUSTERS);
  localparam int KC_W    = $clog2(MAX_CLUSTERS + 1);
  localparam int FT_W    = $clog2(MAX_FEATURES);
  localparam int FC_W    = $clog2(MAX_FEATURES + 1);
  localparam int SUM_W   = SAMPLE_WIDTH + PT_AW;
  localparam int DIFF_W  = SAMPLE_WIDTH + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int DIST_W  = SQ_W + FT_W;
  localparam int KIND_W  = 2;
  localparam int IDX_W   = 10;
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 16;
  localparam int ITER_W  = 16;
  localparam int KREG_W  = 5;
  localparam int FREG_W  = 4;
  localparam logic [ITER_W-1:0] ITER_RESET = 16'd1000;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ASSIGN = 2'd1,
    KIND_CENT   = 2'd2,
    KIND_STATUS = 2'd3
  } kind_t;

  localparam logic [CFG_AW-1:0] CFG_CLUSTERS = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_FEATURES = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_ITERS    = 2'd2;

  typedef logic [MAX_FEATURES-1:0][SAMPLE_WIDTH-1:0] row_t;

  typedef struct packed {
    logic [CNT_W-1:0]                   cnt;
    logic [MAX_FEATURES-1:0][SUM_W-1:0] s;
  } sum_row_t;
endpackage
`default_nettype wire

### sv/kce_dist.sv
// squared distance accumulator, one feature per cycle
`default_nettype none
module kce_dist (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                clr,
  input  wire logic                                en,
  input  wire logic signed [kce_pkg::SAMPLE_WIDTH-1:0] a,
  input  wire logic signed [kce_pkg::SAMPLE_WIDTH-1:0] b,
  output logic        [kce_pkg::DIST_W-1:0]        acc
);
  import kce_pkg::*;

  logic signed [DIFF_W-1:0] diff;
  logic        [DIFF_W-1:0] mag;
  logic        [SQ_W-1:0]   sq;
  logic                     sqv;

  always_comb begin
    diff = DIFF_W'(a) - DIFF_W'(b);
    mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sqv <= 1'b0;
    end else begin
      sqv <= en;
    end
    if (en) begin
      sq <= mag * mag;
    end
    if (clr) begin
      acc <= '0;
    end else if (sqv) begin
      acc <= acc + DIST_W'(sq);
    end
  end
endmodule
`default_nettype wire

### sv/kce_div.sv
// restoring unsigned divider, one quotient bit per cycle
`default_nettype none
module kce_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [kce_pkg::SUM_W-1:0]  dvd,
  input  wire logic [kce_pkg::CNT_W-1:0]  dvs,
  output logic                            busy,
  output logic      [kce_pkg::SUM_W-1:0]  quo
);
  import kce_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvs_q;
  logic [STEP_W-1:0] steps;
  logic [CNT_W:0]    trial;
  logic              fits;

  always_comb begin
    trial = {rem, quo[SUM_W-1]};
    fits  = trial >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= STEP_W'(SUM_W);
      rem   <= '0;
      quo   <= dvd;
      dvs_q <= dvs;
    end else if (busy) begin
      rem   <= fits ? CNT_W'(trial - {1'b0, dvs_q}) : trial[CNT_W-1:0];
      quo   <= {quo[SUM_W-2:0], fits};
      steps <= steps - STEP_W'(1);
      if (steps == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

### sv/kmeans_clustering_engine_core.sv
// k-means clustering engine top level: control sequencer and state memories
// Points load one per cycle into the point memory while the core is idle. A read
// request goes to the output state, an assignment read first through a centroid
// lookup at its assigned cluster, and its beat is registered there once the output
// register is free. A load marked last runs clustering before its status beat: a
// min/max scan, f divider runs for the spacing (none for one cluster), a write of
// the start centroids, then per pass the assignment, the sum accumulation, the
// division of each filled cluster's sums and the pass control, using the single
// distance unit, the one-port sum memory and the bit-serial divider. The status
// beat waits for a free output register before the run's status is published.
`default_nettype none
module kmeans_clustering_engine_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [kce_pkg::KIND_W-1:0]        kind,
  input  wire logic [kce_pkg::IDX_W-1:0]         index,
  input  wire logic signed [kce_pkg::SAMPLE_WIDTH-1:0] feat0,
  input  wire logic signed [kce_pkg::SAMPLE_WIDTH-1:0] feat1,
  input  wire logic signed [kce_pkg::SAMPLE_WIDTH-1:0] feat2,
  input  wire logic signed [kce_pkg::SAMPLE_WIDTH-1:0] feat3,
  input  wire logic signed [kce_pkg::SAMPLE_WIDTH-1:0] feat4,
  input  wire logic signed [kce_pkg::SAMPLE_WIDTH-1:0] feat5,
  input  wire logic signed [kce_pkg::SAMPLE_WIDTH-1:0] feat6,
  input  wire logic signed [kce_pkg::SAMPLE_WIDTH-1:0] feat7,
  input  wire logic                              last_point,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [kce_pkg::CL_W-1:0]               cluster,
  output logic signed [kce_pkg::SAMPLE_WIDTH-1:0] coord0,
  output logic signed [kce_pkg::SAMPLE_WIDTH-1:0] coord1,
  output logic signed [kce_pkg::SAMPLE_WIDTH-1:0] coord2,
  output logic signed [kce_pkg::SAMPLE_WIDTH-1:0] coord3,
  output logic signed [kce_pkg::SAMPLE_WIDTH-1:0] coord4,
  output logic signed [kce_pkg::SAMPLE_WIDTH-1:0] coord5,
  output logic signed [kce_pkg::SAMPLE_WIDTH-1:0] coord6,
  output logic signed [kce_pkg::SAMPLE_WIDTH-1:0] coord7,
  output logic                                   converged,
  output logic [kce_pkg::ITER_W-1:0]             passes_done,
  output logic                                   bad_index,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [kce_pkg::CFG_AW-1:0]        cfg_index,
  input  wire logic [kce_pkg::CFG_DW-1:0]        cfg_data
);
  import kce_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_MM, S_G_ST, S_G_W, S_INIT, S_CHK,
    S_A_PT, S_A_CR, S_A_FEAT, S_A_W1, S_A_CMP, S_A_WR,
    S_U_RD, S_U_SR, S_U_WR,
    S_D_RD, S_D_CHK, S_D_ST, S_D_W, S_D_WR, S_P_END,
    S_DONE, S_R_ASG, S_R_OUT
  } state_t;

  state_t state;

  // memories
  row_t     pmem [MAX_POINTS];
  logic [CL_W-1:0] amem [MAX_POINTS];
  row_t     cmem [MAX_CLUSTERS];
  sum_row_t smem [MAX_CLUSTERS];
  row_t     pm_q, cm_q;
  logic [CL_W-1:0] am_q;
  sum_row_t sm_q;

  logic pm_we, pm_re, am_we, am_re, cm_we, cm_re, sm_we, sm_re;
  logic [PT_AW-1:0] pm_waddr, pm_raddr, am_addr;
  logic [CL_W-1:0]  cm_addr, sm_addr;
  row_t     cm_wdata, in_row, init_row, new_row;
  sum_row_t sm_wdata;

  // config
  logic [KREG_W-1:0] cluster_count;
  logic [FREG_W-1:0] features_used;
  logic [ITER_W-1:0] max_iterations;
  logic [KC_W-1:0]   k_eff;
  logic [FC_W-1:0]   f_eff;

  // control
  logic [CNT_W-1:0]  point_count, pc;
  logic [KC_W-1:0]   cc;
  logic [FC_W-1:0]   fc;
  logic              batch_closed, cent_init, changed, first, mm_v, mm_f, neg;
  logic [ITER_W-1:0] passes;
  logic [MAX_CLUSTERS-1:0] sum_vld;
  logic [MAX_FEATURES-1:0][SAMPLE_WIDTH-1:0] mn, mx, gap, acc_l;
  logic [CL_W-1:0]   best, req_cl;
  logic [DIST_W-1:0] best_d, dist_acc;
  logic              req_bad;
  kind_t             req_kind;
  row_t              out_row;
  logic              in_acc, mm_issue, out_free;

  // divider and distance hookup
  logic             div_start, div_busy;
  logic [SUM_W-1:0] div_dvd, div_q, s_lane, s_mag, div_res;
  logic [CNT_W-1:0] div_dvs;
  logic [DIFF_W-1:0] span;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && (state == S_IDLE);
  assign mm_issue  = (pc < point_count);
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    in_row[0] = feat0; in_row[1] = feat1; in_row[2] = feat2; in_row[3] = feat3;
    in_row[4] = feat4; in_row[5] = feat5; in_row[6] = feat6; in_row[7] = feat7;
  end

  always_comb begin
    if (cluster_count == '0) k_eff = KC_W'(1);
    else if (cluster_count > KREG_W'(MAX_CLUSTERS)) k_eff = KC_W'(MAX_CLUSTERS);
    else k_eff = KC_W'(cluster_count);
    if (features_used == '0) f_eff = FC_W'(1);
    else if (features_used > FREG_W'(MAX_FEATURES)) f_eff = FC_W'(MAX_FEATURES);
    else f_eff = FC_W'(features_used);
  end

  always_comb begin
    span    = DIFF_W'($signed(mx[fc[FT_W-1:0]])) - DIFF_W'($signed(mn[fc[FT_W-1:0]]));
    s_lane  = sm_q.s[fc[FT_W-1:0]];
    s_mag   = s_lane[SUM_W-1] ? SUM_W'(-s_lane) : s_lane;
    div_res = neg ? SUM_W'(-div_q) : div_q;
    div_start = (state == S_G_ST) || (state == S_D_ST);
    if (state == S_G_ST) begin
      div_dvd = SUM_W'(span[SAMPLE_WIDTH-1:0]);
      div_dvs = CNT_W'(k_eff - KC_W'(1));
    end else begin
      div_dvd = s_mag;
      div_dvs = sm_q.cnt;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_FEATURES; i++) begin
      init_row[i] = '0;
      if (FC_W'(i) < f_eff) begin
        if (k_eff == KC_W'(1)) begin
          if (cc == '0) init_row[i] = mn[i];
        end else if (cc < k_eff - KC_W'(1)) begin
          init_row[i] = acc_l[i];
        end else if (cc == k_eff - KC_W'(1)) begin
          init_row[i] = mx[i];
        end
      end
    end
    sm_wdata.cnt = (sum_vld[am_q] ? sm_q.cnt : '0) + CNT_W'(1);
    for (int i = 0; i < MAX_FEATURES; i++) begin
      sm_wdata.s[i] = (sum_vld[am_q] ? sm_q.s[i] : '0) + SUM_W'($signed(pm_q[i]));
    end
  end

  always_comb begin
    pm_we = 1'b0; pm_re = 1'b0; am_we = 1'b0; am_re = 1'b0;
    cm_we = 1'b0; cm_re = 1'b0; sm_we = 1'b0; sm_re = 1'b0;
    pm_waddr = batch_closed ? '0 : point_count[PT_AW-1:0];
    pm_raddr = pc[PT_AW-1:0];
    am_addr  = pc[PT_AW-1:0];
    cm_addr  = cc[CL_W-1:0];
    sm_addr  = cc[CL_W-1:0];
    cm_wdata = new_row;
    unique case (state)
      S_IDLE: begin
        pm_we = in_acc && (kind == KIND_LOAD) &&
                (batch_closed || (point_count < CNT_W'(MAX_POINTS)));
        am_re = in_acc && (kind == KIND_ASSIGN);
        am_addr = PT_AW'(index);
        cm_re = in_acc && (kind == KIND_CENT);
        cm_addr = index[CL_W-1:0];
      end
      S_MM:   pm_re = mm_issue;
      S_A_PT, S_U_RD: begin
        pm_re = 1'b1;
        am_re = 1'b1;
      end
      S_A_CR: cm_re = 1'b1;
      S_A_WR: am_we = 1'b1;
      S_U_SR: begin
        sm_re = 1'b1;
        sm_addr = am_q;
      end
      S_U_WR: begin
        sm_we = 1'b1;
        sm_addr = am_q;
      end
      S_D_RD: begin
        sm_re = 1'b1;
        cm_re = 1'b1;
      end
      S_D_WR: cm_we = 1'b1;
      S_INIT: begin
        cm_we = 1'b1;
        cm_wdata = init_row;
      end
      S_R_ASG: begin
        cm_re = 1'b1;
        cm_addr = am_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pm_we) pmem[pm_waddr] <= in_row;
    if (pm_re) pm_q <= pmem[pm_raddr];
  end

  always_ff @(posedge clk) begin
    if (am_we) amem[am_addr] <= best;
    if (am_re) am_q <= amem[am_addr];
  end

  always_ff @(posedge clk) begin
    if (cm_we) cmem[cm_addr] <= cm_wdata;
    if (cm_re) cm_q <= cmem[cm_addr];
  end

  always_ff @(posedge clk) begin
    if (sm_we) smem[sm_addr] <= sm_wdata;
    if (sm_re) sm_q <= smem[sm_addr];
  end

  kce_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .dvd   (div_dvd),
    .dvs   (div_dvs),
    .busy  (div_busy),
    .quo   (div_q)
  );

  kce_dist u_dist (
    .clk (clk),
    .rst (rst),
    .clr (state == S_A_CR),
    .en  (state == S_A_FEAT),
    .a   ($signed(pm_q[fc[FT_W-1:0]])),
    .b   ($signed(cm_q[fc[FT_W-1:0]])),
    .acc (dist_acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      cluster_count  <= KREG_W'(2);
      features_used  <= FREG_W'(MAX_FEATURES);
      max_iterations <= ITER_RESET;
      point_count    <= '0;
      batch_closed   <= 1'b0;
      converged      <= 1'b0;
      passes_done    <= '0;
      cent_init      <= 1'b0;
      mm_v           <= 1'b0;
      sum_vld        <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_CLUSTERS) cluster_count  <= cfg_data[KREG_W-1:0];
        if (cfg_index == CFG_FEATURES) features_used  <= cfg_data[FREG_W-1:0];
        if (cfg_index == CFG_ITERS)    max_iterations <= cfg_data[ITER_W-1:0];
      end
      if (out_valid && !out_stall && (state != S_R_OUT)) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            req_kind <= kind_t'(kind);
            req_bad  <= 1'b0;
            req_cl   <= index[CL_W-1:0];
            unique case (kind_t'(kind))
              KIND_LOAD: begin
                if (batch_closed) begin
                  point_count  <= CNT_W'(1);
                  batch_closed <= 1'b0;
                end else if (point_count < CNT_W'(MAX_POINTS)) begin
                  point_count <= point_count + CNT_W'(1);
                end
                if (last_point) begin
                  pc    <= '0;
                  mm_v  <= 1'b0;
                  state <= S_MM;
                end
              end
              KIND_ASSIGN: begin
                if (CNT_W'(index) >= point_count) begin
                  req_bad <= 1'b1;
                  state   <= S_R_OUT;
                end else begin
                  state <= S_R_ASG;
                end
              end
              KIND_CENT: begin
                req_bad <= (KC_W'(index) >= k_eff) || (index >= IDX_W'(MAX_CLUSTERS));
                state   <= S_R_OUT;
              end
              KIND_STATUS: state <= S_R_OUT;
            endcase
          end
        end
        S_MM: begin
          mm_v <= mm_issue;
          mm_f <= (pc == '0);
          if (mm_issue) pc <= pc + CNT_W'(1);
          if (mm_v) begin
            for (int i = 0; i < MAX_FEATURES; i++) begin
              if (mm_f || ($signed(pm_q[i]) < $signed(mn[i]))) mn[i] <= pm_q[i];
              if (mm_f || ($signed(pm_q[i]) > $signed(mx[i]))) mx[i] <= pm_q[i];
            end
          end
          if (!mm_issue && !mm_v) begin
            fc <= '0;
            cc <= '0;
            acc_l <= mn;
            state <= (k_eff == KC_W'(1)) ? S_INIT : S_G_ST;
          end
        end
        S_G_ST: state <= S_G_W;
        S_G_W: begin
          if (!div_busy) begin
            gap[fc[FT_W-1:0]] <= div_q[SAMPLE_WIDTH-1:0];
            if (fc == f_eff - FC_W'(1)) begin
              state <= S_INIT;
            end else begin
              fc    <= fc + FC_W'(1);
              state <= S_G_ST;
            end
          end
        end
        S_INIT: begin
          cent_init <= 1'b1;
          for (int i = 0; i < MAX_FEATURES; i++) acc_l[i] <= acc_l[i] + gap[i];
          if (cc == KC_W'(MAX_CLUSTERS - 1)) begin
            passes  <= '0;
            changed <= 1'b1;
            first   <= 1'b1;
            state   <= S_CHK;
          end else begin
            cc <= cc + KC_W'(1);
          end
        end
        S_CHK: begin
          if (changed && (passes < max_iterations)) begin
            changed <= first;
            first   <= 1'b0;
            pc      <= '0;
            state   <= S_A_PT;
          end else begin
            state <= S_DONE;
          end
        end
        S_A_PT: begin
          cc    <= '0;
          state <= S_A_CR;
        end
        S_A_CR: begin
          fc    <= '0;
          state <= S_A_FEAT;
        end
        S_A_FEAT: begin
          fc <= fc + FC_W'(1);
          if (fc == f_eff - FC_W'(1)) state <= S_A_W1;
        end
        S_A_W1: state <= S_A_CMP;
        S_A_CMP: begin
          if ((cc == '0) || (dist_acc < best_d)) begin
            best   <= cc[CL_W-1:0];
            best_d <= dist_acc;
          end
          if (cc == k_eff - KC_W'(1)) begin
            state <= S_A_WR;
          end else begin
            cc    <= cc + KC_W'(1);
            state <= S_A_CR;
          end
        end
        S_A_WR: begin
          if (am_q != best) changed <= 1'b1;
          if (pc == point_count - CNT_W'(1)) begin
            pc      <= '0;
            sum_vld <= '0;
            state   <= S_U_RD;
          end else begin
            pc    <= pc + CNT_W'(1);
            state <= S_A_PT;
          end
        end
        S_U_RD: state <= S_U_SR;
        S_U_SR: state <= S_U_WR;
        S_U_WR: begin
          sum_vld[am_q] <= 1'b1;
          if (pc == point_count - CNT_W'(1)) begin
            cc    <= '0;
            state <= S_D_RD;
          end else begin
            pc    <= pc + CNT_W'(1);
            state <= S_U_RD;
          end
        end
        S_D_RD: state <= S_D_CHK;
        S_D_CHK: begin
          if (!sum_vld[cc[CL_W-1:0]] || (sm_q.cnt == '0)) begin
            if (cc == k_eff - KC_W'(1)) begin
              state <= S_P_END;
            end else begin
              cc    <= cc + KC_W'(1);
              state <= S_D_RD;
            end
          end else begin
            new_row <= cm_q;
            fc      <= '0;
            state   <= S_D_ST;
          end
        end
        S_D_ST: begin
          neg   <= s_lane[SUM_W-1];
          state <= S_D_W;
        end
        S_D_W: begin
          if (!div_busy) begin
            new_row[fc[FT_W-1:0]] <= div_res[SAMPLE_WIDTH-1:0];
            if (fc == f_eff - FC_W'(1)) begin
              state <= S_D_WR;
            end else begin
              fc    <= fc + FC_W'(1);
              state <= S_D_ST;
            end
          end
        end
        S_D_WR: begin
          if (cc == k_eff - KC_W'(1)) begin
            state <= S_P_END;
          end else begin
            cc    <= cc + KC_W'(1);
            state <= S_D_RD;
          end
        end
        S_P_END: begin
          passes <= passes + ITER_W'(1);
          state  <= S_CHK;
        end
        S_DONE: begin
          // status fields ride on the waiting beat, so hold them until it leaves
          if (out_free) begin
            converged    <= !changed;
            passes_done  <= passes;
            batch_closed <= 1'b1;
            req_kind     <= KIND_STATUS;
            req_bad      <= 1'b0;
            state        <= S_R_OUT;
          end
        end
        S_R_ASG: begin
          req_cl <= am_q;
          state  <= S_R_OUT;
        end
        S_R_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            bad_index <= req_bad;
            cluster   <= (req_bad || (req_kind == KIND_STATUS)) ? '0 : req_cl;
            for (int i = 0; i < MAX_FEATURES; i++) begin
              out_row[i] <= (!req_bad && (req_kind != KIND_STATUS) && cent_init &&
                             (FC_W'(i) < f_eff)) ? cm_q[i] : '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign coord0 = $signed(out_row[0]);
  assign coord1 = $signed(out_row[1]);
  assign coord2 = $signed(out_row[2]);
  assign coord3 = $signed(out_row[3]);
  assign coord4 = $signed(out_row[4]);
  assign coord5 = $signed(out_row[5]);
  assign coord6 = $signed(out_row[6]);
  assign coord7 = $signed(out_row[7]);

  a_best_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_A_WR) |-> (KC_W'(best) < k_eff))
    else $error("assigned cluster beyond cluster count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= CNT_W'(MAX_POINTS))
    else $error("point count beyond store depth");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_feat_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_A_FEAT) |-> (fc < f_eff))
    else $error("distance feature beyond feature count");
endmodule
`default_nettype wire
